// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL of the core.
// Both take a label, a property expression and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i, switched off while rst_ni is low.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/ipv4c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4c_pkg
// Types and constants shared by the IPv4 receive frame classifier.
// ----------------------------------------------------------------------------
package ipv4c_pkg;

  localparam int unsigned CountW = 17;

  localparam logic [CountW-1:0] CountMax = '1;

  // Byte positions within the frame
  localparam logic [CountW-1:0] PosTypeHi  = 17'd12;
  localparam logic [CountW-1:0] PosTypeLo  = 17'd13;
  localparam logic [CountW-1:0] PosVerIhl  = 17'd14;
  localparam logic [CountW-1:0] PosTotHi   = 17'd16;
  localparam logic [CountW-1:0] PosTotLo   = 17'd17;
  localparam logic [CountW-1:0] PosProto   = 17'd23;
  localparam logic [CountW-1:0] PosDst0    = 17'd30;
  localparam logic [CountW-1:0] PosDst1    = 17'd31;
  localparam logic [CountW-1:0] PosDst2    = 17'd32;
  localparam logic [CountW-1:0] PosDst3    = 17'd33;

  localparam logic [7:0]  IhlMask       = 8'h0F;
  localparam logic [6:0]  EthHdrBytes   = 7'd14;
  localparam logic [CountW-1:0] MinFrameBytes = 17'd34;
  localparam logic [15:0] Ipv4Ethertype = 16'h0800;
  localparam logic [5:0]  MinIhlBytes   = 6'd20;

  typedef enum logic [1:0] {
    VERDICT_REJECT  = 2'd0,
    VERDICT_OTHER   = 2'd1,
    VERDICT_DELIVER = 2'd2
  } verdict_e;

  // Header fields as they stand once the current beat is captured
  typedef struct packed {
    logic [CountW-1:0] len;
    logic [15:0]       type_word;
    logic [3:0]        header_words;
    logic [15:0]       total_length;
    logic [7:0]        proto_field;
    logic [31:0]       dest_address;
  } hdr_t;

endpackage

// ===== rtl/core/ipv4c_hdr_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4c_hdr_track
// Frame byte counter and capture registers for the Ethernet and IPv4 header
// fields; presents the fields as updated by the current beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4c_hdr_track (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_valid_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output ipv4c_pkg::hdr_t    hdr_o
);

  logic [ipv4c_pkg::CountW-1:0] cnt_q, cnt_d, len;
  logic [15:0] type_q, type_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] tot_q, tot_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] dst_q, dst_d;

  // Saturate the count on very long frames
  assign len = (cnt_q == ipv4c_pkg::CountMax) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    type_d  = type_q;
    ihl_d   = ihl_q;
    tot_d   = tot_q;
    proto_d = proto_q;
    dst_d   = dst_q;
    unique case (cnt_q)
      ipv4c_pkg::PosTypeHi: type_d[15:8]  = data_byte_i;
      ipv4c_pkg::PosTypeLo: type_d[7:0]   = data_byte_i;
      ipv4c_pkg::PosVerIhl: ihl_d         = 4'(data_byte_i & ipv4c_pkg::IhlMask);
      ipv4c_pkg::PosTotHi:  tot_d[15:8]   = data_byte_i;
      ipv4c_pkg::PosTotLo:  tot_d[7:0]    = data_byte_i;
      ipv4c_pkg::PosProto:  proto_d       = data_byte_i;
      ipv4c_pkg::PosDst0:   dst_d[31:24]  = data_byte_i;
      ipv4c_pkg::PosDst1:   dst_d[23:16]  = data_byte_i;
      ipv4c_pkg::PosDst2:   dst_d[15:8]   = data_byte_i;
      ipv4c_pkg::PosDst3:   dst_d[7:0]    = data_byte_i;
      default: ;
    endcase
  end

  assign cnt_d = last_byte_i ? '0 : len;

  assign hdr_o = '{
    len:          len,
    type_word:    type_d,
    header_words: ihl_d,
    total_length: tot_d,
    proto_field:  proto_d,
    dest_address: dst_d
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      type_q  <= '0;
      ihl_q   <= '0;
      tot_q   <= '0;
      proto_q <= '0;
      dst_q   <= '0;
    end else if (beat_valid_i) begin
      cnt_q   <= cnt_d;
      type_q  <= type_d;
      ihl_q   <= ihl_d;
      tot_q   <= tot_d;
      proto_q <= proto_d;
      dst_q   <= dst_d;
    end
  end

  `ASSERT_RST(a_cnt_restart, beat_valid_i && last_byte_i |=> cnt_q == '0,
              "byte count not cleared after frame end")
  `ASSERT_RST(a_cnt_step, beat_valid_i && !last_byte_i && cnt_q != ipv4c_pkg::CountMax
              |=> cnt_q == $past(cnt_q) + 1'b1, "byte count did not advance")

endmodule

// ===== rtl/core/ipv4_rx_frame_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_rx_frame_classifier_core
// Classifies received Ethernet frames as rejected, IPv4 for another host,
// or IPv4 to deliver, with protocol and payload position.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one frame byte per beat (data_byte_i), last_byte_i on the
//                 final byte. Frames follow each other with no gap needed.
//   out channel : one verdict beat per frame, issued from the final byte.
//                 Other bytes give no output beat.
//   cfg channel : writes local_ip_i, always ready; write it while idle.
// Timing: a byte waits in the input register, where its header field is
//   captured; as the final byte leaves it, its verdict is loaded into the
//   output register, which drives out_valid_o. One byte per cycle is
//   sustained unless a final byte is held by a waiting verdict.
// Stalls: while a verdict waits in the output register, bytes keep flowing
//   until the next final byte reaches the input register; it then holds
//   there and in_ready_o drops until the waiting verdict is taken.
// Reset: clears the byte counter, captured fields, local_ip and both valid
//   flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4_rx_frame_classifier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] local_ip_i,
  // frame bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // verdicts
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic [7:0]  protocol_o,
  output logic [6:0]  payload_offset_o,
  output logic [15:0] payload_length_o
);

  logic [31:0] local_ip_q;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic       s1_adv;
  logic       in_accept;

  ipv4c_pkg::hdr_t hdr;

  logic [5:0]  ihl_bytes;
  logic [6:0]  off_bytes;
  logic [ipv4c_pkg::CountW-1:0] need_ihl, need_tot;
  logic        frame_ok;
  ipv4c_pkg::verdict_e verdict;

  logic        out_valid_q, out_valid_d;
  logic        out_load;
  ipv4c_pkg::verdict_e verdict_q;
  logic [7:0]  protocol_q;
  logic [6:0]  offset_q;
  logic [15:0] length_q;

  // --- configuration ---
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= '0;
    end else if (cfg_valid_i) begin
      local_ip_q <= local_ip_i;
    end
  end

  // --- input register ---
  // A final byte advances only when the output register can take its verdict
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;
  assign s1_valid_d = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  ipv4c_hdr_track u_hdr_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (s1_adv),
    .data_byte_i  (s1_data_q),
    .last_byte_i  (s1_last_q),
    .hdr_o        (hdr)
  );

  // --- verdict ---
  assign ihl_bytes = {hdr.header_words, 2'b00};
  assign off_bytes = ipv4c_pkg::EthHdrBytes + {1'b0, ihl_bytes};
  assign need_ihl  = {{(ipv4c_pkg::CountW-7){1'b0}}, off_bytes};
  assign need_tot  = {1'b0, hdr.total_length} + {{(ipv4c_pkg::CountW-7){1'b0}},
                                                  ipv4c_pkg::EthHdrBytes};

  assign frame_ok = (hdr.len >= ipv4c_pkg::MinFrameBytes)
                 && (hdr.type_word == ipv4c_pkg::Ipv4Ethertype)
                 && (ihl_bytes >= ipv4c_pkg::MinIhlBytes)
                 && (hdr.len >= need_ihl)
                 && (hdr.total_length >= {10'b0, ihl_bytes})
                 && (hdr.len >= need_tot);

  always_comb begin
    priority if (!frame_ok) begin
      verdict = ipv4c_pkg::VERDICT_REJECT;
    end else if (hdr.dest_address == local_ip_q) begin
      verdict = ipv4c_pkg::VERDICT_DELIVER;
    end else begin
      verdict = ipv4c_pkg::VERDICT_OTHER;
    end
  end

  // --- output register ---
  assign out_load    = s1_adv && s1_last_q;
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_q  <= verdict;
      protocol_q <= frame_ok ? hdr.proto_field : 8'd0;
      offset_q   <= frame_ok ? off_bytes : 7'd0;
      length_q   <= frame_ok ? hdr.total_length - {10'b0, ihl_bytes} : 16'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign protocol_o       = protocol_q;
  assign payload_offset_o = offset_q;
  assign payload_length_o = length_q;

  `ASSERT_ALWAYS(a_stall_cause, !in_ready_o |-> s1_valid_q && s1_last_q && out_valid_q
                 && !out_ready_i, "input stalled without a waiting verdict")
  `ASSERT_RST(a_reject_zero, out_valid_o && verdict_o == ipv4c_pkg::VERDICT_REJECT
              |-> protocol_o == 8'd0 && payload_offset_o == 7'd0
              && payload_length_o == 16'd0, "rejected verdict carries field data")
  `ASSERT_RST(a_accept_offset, out_valid_o && verdict_o != ipv4c_pkg::VERDICT_REJECT
              |-> payload_offset_o >= 7'd34, "accepted verdict with short header")
  `ASSERT_RST(a_no_overwrite, out_valid_q && !out_ready_i |-> !out_load,
              "waiting verdict overwritten")

endmodule
